FILE: design/dsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_pkg
// types, codes and constants shared by the delimiter-separated value parser
// ----------------------------------------------------------------------------
package dsv_pkg;

    localparam int MAX_HELD_BLANKS = 32;
    localparam int HELD_CNT_W      = $clog2(MAX_HELD_BLANKS + 1);
    localparam int HELD_IDX_W      = (MAX_HELD_BLANKS > 1) ? $clog2(MAX_HELD_BLANKS) : 1;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 1'd1;

    typedef enum logic [2:0] {
        KIND_DATA  = 3'd0,
        KIND_FIELD = 3'd1,
        KIND_LINE  = 3'd2,
        KIND_INPUT = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    localparam logic [1:0] ERR_SEP_EXPECTED = 2'd0;
    localparam logic [1:0] ERR_OPEN_QUOTE   = 2'd1;
    localparam logic [1:0] ERR_HOLD_FULL    = 2'd2;
    localparam logic [1:0] ERR_NONE         = 2'd0;

    typedef enum logic [5:0] {
        PH_START    = 6'b000001,
        PH_UNQUOTED = 6'b000010,
        PH_QUOTED   = 6'b000100,
        PH_QSEEN    = 6'b001000,
        PH_AFTER    = 6'b010000,
        PH_ERROR    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] out_kind;
        logic [7:0] out_byte;
        logic [1:0] error_code;
        logic       last_of_run;
    } out_beat_t;

    // results caused by one item: released blanks, then primary, then secondary
    typedef struct packed {
        logic                       has_run;
        logic [HELD_CNT_W-1:0]      blank_cnt;
        logic [MAX_HELD_BLANKS-1:0] blank_kinds;
        kind_t                      prim_kind;
        logic [7:0]                 prim_byte;
        logic [1:0]                 prim_code;
        logic                       sec_valid;
        kind_t                      sec_kind;
        logic [1:0]                 sec_code;
    } run_t;

    typedef struct packed {
        logic run_free;
        logic run_busy;
    } emit_status_t;

endpackage
`default_nettype wire

FILE: design/dsv_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_parse_core
// config registers, parse phase and held blanks; decodes one beat into a run
// ----------------------------------------------------------------------------
module dsv_parse_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [dsv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [7:0]                          cfg_data,
    input  wire logic                                take,
    input  wire dsv_pkg::in_beat_t                   beat,
    output dsv_pkg::run_t                            run
);

    logic [7:0]                           sep_reg;
    logic [7:0]                           quote_reg;
    dsv_pkg::phase_t                      phase_reg;
    dsv_pkg::phase_t                      phase_next;
    logic [dsv_pkg::HELD_CNT_W-1:0]       held_cnt_reg;
    logic [dsv_pkg::HELD_CNT_W-1:0]       held_cnt_next;
    logic [dsv_pkg::MAX_HELD_BLANKS-1:0]  held_kinds_reg;
    logic [dsv_pkg::MAX_HELD_BLANKS-1:0]  held_kinds_next;

    logic [7:0] b;
    logic       is_blank;
    logic       is_nl;
    logic       is_sep;
    logic       is_quote;
    logic       hold_full;

    assign b         = beat.in_byte;
    assign is_blank  = (b == dsv_pkg::CHAR_SPACE) || (b == dsv_pkg::CHAR_TAB);
    assign is_nl     = (b == dsv_pkg::CHAR_NEWLINE);
    assign is_sep    = (b == sep_reg);
    assign is_quote  = (b == quote_reg);
    assign hold_full = held_cnt_reg >= dsv_pkg::HELD_CNT_W'(dsv_pkg::MAX_HELD_BLANKS);

    always_comb
    begin
        phase_next      = phase_reg;
        held_cnt_next   = held_cnt_reg;
        held_kinds_next = held_kinds_reg;
        run             = '0;
        run.prim_kind   = dsv_pkg::KIND_DATA;
        run.sec_kind    = dsv_pkg::KIND_DATA;

        if (beat.end_of_input)
        begin
            run.has_run = 1'b1;
            if (phase_reg inside {dsv_pkg::PH_UNQUOTED, dsv_pkg::PH_QSEEN})
            begin
                run.prim_kind = dsv_pkg::KIND_FIELD;
                run.sec_valid = 1'b1;
                run.sec_kind  = dsv_pkg::KIND_INPUT;
            end
            else if (phase_reg == dsv_pkg::PH_QUOTED)
            begin
                run.prim_kind = dsv_pkg::KIND_ERROR;
                run.prim_code = dsv_pkg::ERR_OPEN_QUOTE;
            end
            else
            begin
                run.prim_kind = dsv_pkg::KIND_INPUT;
            end
            phase_next      = (phase_reg == dsv_pkg::PH_QUOTED) ? dsv_pkg::PH_ERROR
                                                                : dsv_pkg::PH_START;
            held_cnt_next   = '0;
            held_kinds_next = '0;
        end
        else
        begin
            case (phase_reg)
                dsv_pkg::PH_START:
                begin
                    if (is_blank)
                    begin
                        phase_next = dsv_pkg::PH_START;
                    end
                    else if (is_nl)
                    begin
                        run.has_run   = 1'b1;
                        run.prim_kind = dsv_pkg::KIND_LINE;
                    end
                    else if (is_sep)
                    begin
                        run.has_run   = 1'b1;
                        run.prim_kind = dsv_pkg::KIND_FIELD;
                    end
                    else if (is_quote)
                    begin
                        phase_next = dsv_pkg::PH_QUOTED;
                    end
                    else
                    begin
                        run.has_run     = 1'b1;
                        run.prim_byte   = b;
                        phase_next      = dsv_pkg::PH_UNQUOTED;
                        held_cnt_next   = '0;
                        held_kinds_next = '0;
                    end
                end
                dsv_pkg::PH_UNQUOTED:
                begin
                    if (is_nl || is_sep)
                    begin
                        run.has_run     = 1'b1;
                        run.prim_kind   = dsv_pkg::KIND_FIELD;
                        run.sec_valid   = is_nl;
                        run.sec_kind    = dsv_pkg::KIND_LINE;
                        phase_next      = dsv_pkg::PH_START;
                        held_cnt_next   = '0;
                        held_kinds_next = '0;
                    end
                    else if (is_blank)
                    begin
                        if (hold_full)
                        begin
                            run.has_run     = 1'b1;
                            run.prim_kind   = dsv_pkg::KIND_ERROR;
                            run.prim_code   = dsv_pkg::ERR_HOLD_FULL;
                            phase_next      = dsv_pkg::PH_ERROR;
                            held_cnt_next   = '0;
                            held_kinds_next = '0;
                        end
                        else
                        begin
                            if (b == dsv_pkg::CHAR_TAB)
                            begin
                                held_kinds_next[held_cnt_reg[dsv_pkg::HELD_IDX_W-1:0]] = 1'b1;
                            end
                            held_cnt_next = held_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        run.has_run     = 1'b1;
                        run.blank_cnt   = held_cnt_reg;
                        run.blank_kinds = held_kinds_reg;
                        run.prim_byte   = b;
                        held_cnt_next   = '0;
                        held_kinds_next = '0;
                    end
                end
                dsv_pkg::PH_QUOTED:
                begin
                    if (is_quote)
                    begin
                        phase_next = dsv_pkg::PH_QSEEN;
                    end
                    else
                    begin
                        run.has_run   = 1'b1;
                        run.prim_byte = b;
                    end
                end
                dsv_pkg::PH_QSEEN:
                begin
                    run.has_run = 1'b1;
                    if (is_quote)
                    begin
                        run.prim_byte = b;
                        phase_next    = dsv_pkg::PH_QUOTED;
                    end
                    else
                    begin
                        run.prim_kind = dsv_pkg::KIND_FIELD;
                        if (is_blank)
                        begin
                            phase_next = dsv_pkg::PH_AFTER;
                        end
                        else if (is_nl)
                        begin
                            run.sec_valid = 1'b1;
                            run.sec_kind  = dsv_pkg::KIND_LINE;
                            phase_next    = dsv_pkg::PH_START;
                        end
                        else if (is_sep)
                        begin
                            phase_next = dsv_pkg::PH_START;
                        end
                        else
                        begin
                            run.sec_valid = 1'b1;
                            run.sec_kind  = dsv_pkg::KIND_ERROR;
                            run.sec_code  = dsv_pkg::ERR_SEP_EXPECTED;
                            phase_next    = dsv_pkg::PH_ERROR;
                        end
                    end
                end
                dsv_pkg::PH_AFTER:
                begin
                    if (is_blank)
                    begin
                        phase_next = dsv_pkg::PH_AFTER;
                    end
                    else if (is_nl)
                    begin
                        run.has_run   = 1'b1;
                        run.prim_kind = dsv_pkg::KIND_LINE;
                        phase_next    = dsv_pkg::PH_START;
                    end
                    else if (is_sep)
                    begin
                        phase_next = dsv_pkg::PH_START;
                    end
                    else
                    begin
                        run.has_run   = 1'b1;
                        run.prim_kind = dsv_pkg::KIND_ERROR;
                        run.prim_code = dsv_pkg::ERR_SEP_EXPECTED;
                        phase_next    = dsv_pkg::PH_ERROR;
                    end
                end
                default:
                begin
                    phase_next = dsv_pkg::PH_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg        <= dsv_pkg::SEPARATOR_RESET;
            quote_reg      <= dsv_pkg::QUOTE_RESET;
            phase_reg      <= dsv_pkg::PH_START;
            held_cnt_reg   <= '0;
            held_kinds_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    dsv_pkg::CFG_SEPARATOR: sep_reg   <= cfg_data;
                    dsv_pkg::CFG_QUOTE:     quote_reg <= cfg_data;
                    default:                sep_reg   <= sep_reg;
                endcase
            end
            if (take)
            begin
                phase_reg      <= phase_next;
                held_cnt_reg   <= held_cnt_next;
                held_kinds_reg <= held_kinds_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/dsv_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_emitter
// run register drained one result per cycle into the output register while that register is empty or being read
// ----------------------------------------------------------------------------
module dsv_emitter
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire dsv_pkg::run_t          run,
    output dsv_pkg::emit_status_t       status,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output dsv_pkg::out_beat_t          out_data
);

    logic                                run_valid_reg;
    logic                                prim_done_reg;
    logic [dsv_pkg::HELD_CNT_W-1:0]      blank_cnt_reg;
    logic [dsv_pkg::MAX_HELD_BLANKS-1:0] blank_kinds_reg;
    dsv_pkg::kind_t                      prim_kind_reg;
    logic [7:0]                          prim_byte_reg;
    logic [1:0]                          prim_code_reg;
    logic                                sec_valid_reg;
    dsv_pkg::kind_t                      sec_kind_reg;
    logic [1:0]                          sec_code_reg;

    logic                                out_valid_reg;
    dsv_pkg::out_beat_t                  out_reg;

    dsv_pkg::out_beat_t                  cur;
    logic                                advance;
    logic                                in_blanks;

    assign in_blanks = (blank_cnt_reg != '0);
    assign advance   = run_valid_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        cur = '0;
        if (in_blanks)
        begin
            cur.out_kind = dsv_pkg::KIND_DATA;
            cur.out_byte = blank_kinds_reg[0] ? dsv_pkg::CHAR_TAB : dsv_pkg::CHAR_SPACE;
        end
        else if (!prim_done_reg)
        begin
            cur.out_kind    = prim_kind_reg;
            cur.out_byte    = prim_byte_reg;
            cur.error_code  = prim_code_reg;
            cur.last_of_run = !sec_valid_reg;
        end
        else
        begin
            cur.out_kind    = sec_kind_reg;
            cur.error_code  = sec_code_reg;
            cur.last_of_run = 1'b1;
        end
    end

    assign status.run_busy = run_valid_reg;
    assign status.run_free = !run_valid_reg || (advance && cur.last_of_run);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            prim_done_reg <= 1'b0;
            blank_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                run_valid_reg <= 1'b1;
                prim_done_reg <= 1'b0;
                blank_cnt_reg <= run.blank_cnt;
            end
            else if (advance)
            begin
                if (in_blanks)
                begin
                    blank_cnt_reg <= blank_cnt_reg - 1'b1;
                end
                else if (!prim_done_reg && sec_valid_reg)
                begin
                    prim_done_reg <= 1'b1;
                end
                else
                begin
                    run_valid_reg <= 1'b0;
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            blank_kinds_reg <= run.blank_kinds;
            prim_kind_reg   <= run.prim_kind;
            prim_byte_reg   <= run.prim_byte;
            prim_code_reg   <= run.prim_code;
            sec_valid_reg   <= run.sec_valid;
            sec_kind_reg    <= run.sec_kind;
            sec_code_reg    <= run.sec_code;
        end
        else if (advance && in_blanks)
        begin
            blank_kinds_reg <= blank_kinds_reg >> 1;
        end
        if (advance)
        begin
            out_reg <= cur;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

FILE: design/dsv_field_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_field_parser
// streaming parser splitting delimiter-separated lines into field results
// ----------------------------------------------------------------------------
// the first result of a beat passes through the run register, then the output register
// throughput: one beat per cycle while each beat yields at most one result and the
// output does not stall; beats with no result load nothing; a beat with more holds
// the run register until its last result is out (held blanks drain one per unstalled cycle)
// reset: separator 0x2c, quote 0x22, field start phase, no blanks held
// ----------------------------------------------------------------------------
module dsv_field_parser
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire dsv_pkg::in_beat_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output dsv_pkg::out_beat_t                 out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dsv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data
);

    dsv_pkg::run_t         run;
    dsv_pkg::emit_status_t status;
    logic                  take;

    assign cfg_ready = 1'b1;
    assign in_ready  = status.run_free;
    assign take      = in_valid && in_ready;

    dsv_parse_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .beat      (in_data),
        .run       (run)
    );

    dsv_emitter u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && run.has_run),
        .run       (run),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // an end mark always leaves a run to drain
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.end_of_input) |=> status.run_busy)
        else $error("end mark accepted without a run");

    // line end, input end and error close the run of their beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.out_kind == dsv_pkg::KIND_LINE ||
                       out_data.out_kind == dsv_pkg::KIND_INPUT ||
                       out_data.out_kind == dsv_pkg::KIND_ERROR))
        |-> out_data.last_of_run)
        else $error("terminal result not marked last");

    // only released blanks are data results ahead of the final one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.out_kind == dsv_pkg::KIND_DATA && !out_data.last_of_run)
        |-> (out_data.out_byte == dsv_pkg::CHAR_SPACE ||
             out_data.out_byte == dsv_pkg::CHAR_TAB))
        else $error("non-blank data before end of run");

endmodule
`default_nettype wire

FILE: dv/dsv_field_parser_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_field_parser_chk
// watches the parser channels, predicts the results of every accepted beat
// from its own copy of parse state and registers, and compares them in order
// ----------------------------------------------------------------------------
module dsv_field_parser_chk
    import dsv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_beat_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_beat_t            out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output int                   fail_count,
    output int                   pending
);

    logic [7:0]                 sep_char;
    logic [7:0]                 quote_char;
    phase_t                     phase;
    int                         held_cnt;
    logic [MAX_HELD_BLANKS-1:0] held_tabs;
    out_beat_t                  beat_results[$];
    out_beat_t                  expected_beats[$];

    function automatic bit is_blank(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_TAB);
    endfunction

    task automatic add_result(input kind_t kind, input logic [7:0] b, input logic [1:0] code);
        out_beat_t r;
        r.out_kind    = kind;
        r.out_byte    = b;
        r.error_code  = code;
        r.last_of_run = 1'b0;
        beat_results.push_back(r);
    endtask

    task automatic drop_held();
        held_cnt  = 0;
        held_tabs = '0;
    endtask

    // byte following a closed field
    task automatic after_field_byte(input logic [7:0] b);
        if (is_blank(b))
            phase = PH_AFTER;
        else if (b == CHAR_NEWLINE)
        begin
            add_result(KIND_LINE, 8'h00, ERR_NONE);
            phase = PH_START;
        end
        else if (b == sep_char)
            phase = PH_START;
        else
        begin
            add_result(KIND_ERROR, 8'h00, ERR_SEP_EXPECTED);
            phase = PH_ERROR;
        end
    endtask

    task automatic parse_beat(input in_beat_t beat);
        logic [7:0] b;
        b = beat.in_byte;
        beat_results.delete();
        if (beat.end_of_input)
        begin
            case (phase)
                PH_UNQUOTED, PH_QSEEN:
                begin
                    add_result(KIND_FIELD, 8'h00, ERR_NONE);
                    add_result(KIND_INPUT, 8'h00, ERR_NONE);
                end
                PH_QUOTED:
                    add_result(KIND_ERROR, 8'h00, ERR_OPEN_QUOTE);
                default:
                    add_result(KIND_INPUT, 8'h00, ERR_NONE);
            endcase
            if (phase == PH_QUOTED)
                phase = PH_ERROR;
            else
                phase = PH_START;
            drop_held();
        end
        else
        begin
            case (phase)
                PH_START:
                begin
                    if (is_blank(b))
                        phase = PH_START;
                    else if (b == CHAR_NEWLINE)
                        add_result(KIND_LINE, 8'h00, ERR_NONE);
                    else if (b == sep_char)
                        add_result(KIND_FIELD, 8'h00, ERR_NONE);
                    else if (b == quote_char)
                        phase = PH_QUOTED;
                    else
                    begin
                        add_result(KIND_DATA, b, ERR_NONE);
                        phase = PH_UNQUOTED;
                        drop_held();
                    end
                end
                PH_UNQUOTED:
                begin
                    if (b == CHAR_NEWLINE || b == sep_char)
                    begin
                        add_result(KIND_FIELD, 8'h00, ERR_NONE);
                        if (b == CHAR_NEWLINE)
                            add_result(KIND_LINE, 8'h00, ERR_NONE);
                        phase = PH_START;
                        drop_held();
                    end
                    else if (is_blank(b))
                    begin
                        if (held_cnt >= MAX_HELD_BLANKS)
                        begin
                            add_result(KIND_ERROR, 8'h00, ERR_HOLD_FULL);
                            phase = PH_ERROR;
                            drop_held();
                        end
                        else
                        begin
                            held_tabs[held_cnt] = (b == CHAR_TAB);
                            held_cnt++;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < held_cnt; i++)
                            add_result(KIND_DATA, held_tabs[i] ? CHAR_TAB : CHAR_SPACE, ERR_NONE);
                        drop_held();
                        add_result(KIND_DATA, b, ERR_NONE);
                    end
                end
                PH_QUOTED:
                begin
                    if (b == quote_char)
                        phase = PH_QSEEN;
                    else
                        add_result(KIND_DATA, b, ERR_NONE);
                end
                PH_QSEEN:
                begin
                    if (b == quote_char)
                    begin
                        add_result(KIND_DATA, b, ERR_NONE);
                        phase = PH_QUOTED;
                    end
                    else
                    begin
                        add_result(KIND_FIELD, 8'h00, ERR_NONE);
                        after_field_byte(b);
                    end
                end
                PH_AFTER:
                    after_field_byte(b);
                default:
                    phase = PH_ERROR;
            endcase
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_beat_t r;
        out_beat_t want;
        if (!rst_n)
        begin
            sep_char   = SEPARATOR_RESET;
            quote_char = QUOTE_RESET;
            phase      = PH_START;
            drop_held();
            expected_beats.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SEPARATOR)
                    sep_char = cfg_data;
                else if (cfg_index == CFG_QUOTE)
                    quote_char = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                parse_beat(in_data);
                foreach (beat_results[i])
                begin
                    r             = beat_results[i];
                    r.last_of_run = (i == beat_results.size() - 1);
                    expected_beats.push_back(r);
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: result mismatch, expected none, actual kind %0d byte %0d code %0d last %0d",
                             $time, out_data.out_kind, out_data.out_byte,
                             out_data.error_code, out_data.last_of_run);
                    fail_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    compare_field("out_kind", want.out_kind, out_data.out_kind);
                    compare_field("out_byte", want.out_byte, out_data.out_byte);
                    compare_field("error_code", want.error_code, out_data.error_code);
                    compare_field("last_of_run", want.last_of_run, out_data.last_of_run);
                end
            end
            pending <= expected_beats.size();
        end
    end

endmodule

FILE: dv/dsv_field_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_field_parser_tb
// drives directed and random delimiter-separated text through the parser
// under several separator and quote settings, with random idling on both
// channels, a long output hold-off and drained pauses; the checker compares
// ----------------------------------------------------------------------------
module dsv_field_parser_tb;
    import dsv_pkg::*;

    localparam int LONG_HOLD  = 300;
    localparam int SETTLE     = 10;
    localparam int TIMEOUT_NS = 10_000_000;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_beat_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_beat_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;
    int                   fail_count;
    int                   pending;

    bit                   no_idle   = 1'b0;
    bit                   hold_req  = 1'b0;
    int                   items_sent = 0;
    logic [7:0]           cur_sep   = SEPARATOR_RESET;
    logic [7:0]           cur_quote = QUOTE_RESET;

    dsv_field_parser u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dsv_field_parser_chk u_chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("dsv_field_parser_tb NOT OK");
        $finish;
    end

    // output side: random stall per beat, occasional long hold-off
    initial
    begin : receiver
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic eoi);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, end_of_input: eoi};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_blank();
        return ($urandom_range(0, 1) != 0) ? CHAR_TAB : CHAR_SPACE;
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_NEWLINE ||
               b == cur_sep || b == cur_quote)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic send_blanks(input int n);
        repeat (n) send_beat(pick_blank(), 1'b0);
    endtask

    task automatic send_eoi();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // one line of fields: unquoted, quoted or empty, with random padding
    task automatic send_record();
        int fields;
        int style;
        fields = $urandom_range(1, 4);
        for (int f = 0; f < fields; f++)
        begin
            if (f > 0)
                send_beat(cur_sep, 1'b0);
            send_blanks($urandom_range(0, 2));
            style = $urandom_range(0, 9);
            if (style < 5)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_blanks($urandom_range(1, 3));
                    send_beat(pick_plain(), 1'b0);
                end
                send_blanks($urandom_range(0, 3));
            end
            else if (style < 8)
            begin
                send_beat(cur_quote, 1'b0);
                repeat ($urandom_range(0, 5))
                begin
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            send_beat(cur_quote, 1'b0);
                            send_beat(cur_quote, 1'b0);
                        end
                        1:       send_beat(cur_sep, 1'b0);
                        2:       send_beat(CHAR_NEWLINE, 1'b0);
                        3:       send_blanks(1);
                        default: send_beat(pick_plain(), 1'b0);
                    endcase
                end
                send_beat(cur_quote, 1'b0);
                send_blanks($urandom_range(0, 2));
            end
        end
        case ($urandom_range(0, 9))
            0:       send_eoi();
            1:       ;
            default: send_beat(CHAR_NEWLINE, 1'b0);
        endcase
    endtask

    // malformed input, always closed by an end-of-input beat
    task automatic send_broken();
        case ($urandom_range(0, 2))
            0:
            begin
                send_beat(cur_quote, 1'b0);
                send_beat(pick_plain(), 1'b0);
                send_beat(cur_quote, 1'b0);
                send_beat(pick_plain(), 1'b0);
                send_beat(pick_plain(), 1'b0);
            end
            1:
            begin
                send_beat(cur_quote, 1'b0);
                send_beat(pick_plain(), 1'b0);
                send_eoi();
            end
            default:
                repeat ($urandom_range(1, 6)) send_beat(8'($urandom_range(0, 255)), 1'b0);
        endcase
        send_eoi();
    endtask

    task automatic send_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 8)
                send_record();
            else
                send_broken();
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SEPARATOR)
            cur_sep = val;
        else
            cur_quote = val;
    endtask

    task automatic run_phase(input logic [7:0] sep, input logic [7:0] quote, input int count,
                             input bit quiet, input bit hold);
        wait_idle();
        write_reg(CFG_SEPARATOR, sep);
        write_reg(CFG_QUOTE, quote);
        no_idle  = quiet;
        hold_req = hold;
        send_random(count);
        no_idle  = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // blanks skipped, held blank released, byte extremes, empty field, bare newline
        send_text(" \t");
        send_beat(8'h00, 1'b0);
        send_text(" ");
        send_beat(8'hFF, 1'b0);
        send_text(",,\n");
        // doubled quote, newline inside quotes, blank then newline after close
        send_text("\"x\"\"\n\" \n");
        // end inside unquoted field, end at field start, end after closing quote
        send_text("k");
        send_eoi();
        send_eoi();
        send_text("\"q\"");
        send_eoi();
        // separator expected, ignored byte, end
        send_text("\"p\"mj");
        send_eoi();
        // end inside open quote, then end in error state
        send_text("\"r");
        send_eoi();
        send_eoi();

        // full blank hold released, then hold overflow
        send_text("x");
        send_blanks(MAX_HELD_BLANKS);
        send_text("y\nx");
        send_blanks(MAX_HELD_BLANKS + 1);
        send_text("z");
        send_eoi();

        send_random(34);
        run_phase(8'h00, 8'hFF, 30, 1'b0, 1'b1);
        run_phase(8'hFF, 8'h00, 30, 1'b1, 1'b0);
        run_phase(";", "'", 30, 1'b0, 1'b0);
        run_phase("|", "|", 20, 1'b0, 1'b0);
        run_phase(CHAR_SPACE, CHAR_NEWLINE, 20, 1'b0, 1'b0);
        run_phase(SEPARATOR_RESET, QUOTE_RESET, 20, 1'b0, 1'b1);
        wait_idle();

        if (fail_count == 0)
            $display("dsv_field_parser_tb OK");
        else
            $display("dsv_field_parser_tb NOT OK");
        $finish;
    end

endmodule
